@@ sv/gprf_pkg.sv @@
// Shared types and constants for the gamepad report formatter.
`timescale 1ns / 1ps

package gprf_pkg;

  // Report layout codes held in the format register
  localparam logic [1:0] FMT_GENERIC = 2'd0;
  localparam logic [1:0] FMT_LAYOUT1 = 2'd1;
  localparam logic [1:0] FMT_LAYOUT2 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FORMAT    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_LENGTH    = 2'd2;
  localparam logic [1:0] REG_ID        = 2'd3;

  localparam int unsigned LEN_W = 7;

  // Snapshot as stored in the buffer memory, sticks already scaled
  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  trig_l;
    logic [7:0]  trig_r;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  count;
  } snap_t;

  // Live configuration seen by the byte generator
  typedef struct packed {
    logic [1:0] format;
    logic [7:0] threshold;
    logic [7:0] id;
  } cfg_t;

endpackage

@@ sv/gprf_byte_gen.sv @@
// Report byte generator: one report byte from a stored snapshot and a byte position.
`timescale 1ns / 1ps

module gprf_byte_gen (
  input  gprf_pkg::snap_t snap,
  input  gprf_pkg::cfg_t  cfg,
  input  logic [5:0]      idx,
  output logic [7:0]      value
);

  logic [15:0] b;
  logic        ltd;
  logic        rtd;
  logic        up, dn, lf, rt, h_r, h_l;
  logic [3:0]  hat;
  logic [7:0]  ff_up, ff_dn, ff_lf, ff_rt, ff_lb, ff_rb, ff_y, ff_b, ff_a, ff_x;

  assign b   = snap.buttons;
  assign ltd = (snap.trig_l >= cfg.threshold);
  assign rtd = (snap.trig_r >= cfg.threshold);

  assign up  = b[0];
  assign dn  = b[1];
  assign lf  = b[2];
  assign rt  = b[3];
  assign h_r = rt & ~lf;
  assign h_l = lf & ~rt;

  // Opposing directions cancel on each axis
  always_comb begin
    if (up && !dn) begin
      hat = h_r ? 4'd1 : (h_l ? 4'd7 : 4'd0);
    end else if (dn && !up) begin
      hat = h_r ? 4'd3 : (h_l ? 4'd5 : 4'd4);
    end else if (h_r) begin
      hat = 4'd2;
    end else if (h_l) begin
      hat = 4'd6;
    end else begin
      hat = 4'd8;
    end
  end

  assign ff_up = {8{b[0]}};
  assign ff_dn = {8{b[1]}};
  assign ff_lf = {8{b[2]}};
  assign ff_rt = {8{b[3]}};
  assign ff_lb = {8{b[8]}};
  assign ff_rb = {8{b[9]}};
  assign ff_a  = {8{b[12]}};
  assign ff_b  = {8{b[13]}};
  assign ff_x  = {8{b[14]}};
  assign ff_y  = {8{b[15]}};

  always_comb begin
    value = 8'h00;
    case (cfg.format)
      gprf_pkg::FMT_GENERIC: begin
        case (idx)
          6'd0: value = {rtd, ltd, b[9], b[8], b[15], b[13], b[12], b[14]};
          6'd1: value = {4'h0, b[7], b[6], b[4], b[5]};
          6'd2: value = snap.lx;
          6'd3: value = snap.ly;
          6'd4: value = snap.rx;
          6'd5: value = snap.ry;
          6'd6: value = snap.trig_l;
          6'd7: value = snap.trig_r;
          default: value = 8'h00;
        endcase
      end
      gprf_pkg::FMT_LAYOUT1: begin
        case (idx)
          6'd0:  value = cfg.id;
          6'd2:  value = {b[2], b[1], b[3], b[0], b[4], b[7], b[6], b[5]};
          6'd3:  value = {b[14], b[12], b[13], b[15], b[9], b[8], rtd, ltd};
          6'd4:  value = {7'h00, b[10]};
          6'd6:  value = snap.lx;
          6'd7:  value = snap.ly;
          6'd8:  value = snap.rx;
          6'd9:  value = snap.ry;
          6'd14: value = ff_up;
          6'd15: value = ff_rt;
          6'd16: value = ff_dn;
          6'd17: value = ff_lf;
          6'd18: value = snap.trig_l;
          6'd19: value = snap.trig_r;
          6'd20: value = ff_lb;
          6'd21: value = ff_rb;
          6'd22: value = ff_y;
          6'd23: value = ff_b;
          6'd24: value = ff_a;
          6'd25: value = ff_x;
          6'd29: value = 8'h02;
          6'd30: value = 8'h05;
          6'd31: value = 8'h10;
          6'd41, 6'd43, 6'd45, 6'd47: value = 8'h01;
          6'd42, 6'd44, 6'd46, 6'd48: value = 8'hFF;
          default: value = 8'h00;
        endcase
      end
      default: begin
        // Layout 2 and the unused code 3
        case (idx)
          6'd0:  value = cfg.id;
          6'd1:  value = snap.lx;
          6'd2:  value = snap.ly;
          6'd3:  value = snap.rx;
          6'd4:  value = snap.ry;
          6'd5:  value = {b[15], b[13], b[12], b[14], hat};
          6'd6:  value = {b[7], b[6], b[4], b[5], rtd, ltd, b[9], b[8]};
          6'd7:  value = {snap.count[5:0], 1'b0, b[10]};
          6'd8:  value = snap.trig_l;
          6'd9:  value = snap.trig_r;
          6'd10: value = {snap.count[5:0], 2'b00};
          6'd11: value = {6'h00, snap.count[7:6]};
          6'd30: value = 8'h1B;
          6'd33: value = 8'h01;
          default: value = 8'h00;
        endcase
      end
    endcase
  end

endmodule

@@ sv/gamepad_report_formatter_core.sv @@
// Top level of the gamepad report formatter: snapshot buffer, byte sequencer, output register.
//
// Snapshots arrive on the s_axis channel, one request per snapshot. The sticks are
// scaled on entry and the snapshot is written into a two-entry buffer memory. A
// sequencer reads one entry (registered read) and walks the report, one byte per cycle
// while m_axis does not stall, into the m_axis output register; tlast marks the final byte.
// A report holds report_length bytes, clamped to 1..MAX_REPORT_BYTES.
// An accepted request passes the buffer memory and its registered read before its first
// byte is registered in the output register. Throughput: one byte per cycle while m_axis
// does not stall; the next buffer read is issued with the final byte, so reports follow
// each other with no gap. The sequencer's one byte per cycle sets this.
// s_axis_tready drops only while both buffer entries wait to be read.
// A stall on m_axis holds the output register and the sequencer; input requests
// are still taken while buffer space remains.
// Reset (rst, synchronous) empties the buffer, drops any report in progress and
// loads the registers: layout 2, threshold 128, length 64, report id 1.
`timescale 1ns / 1ps

module gamepad_report_formatter_core #(
  parameter int unsigned MAX_REPORT_BYTES = 64
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  // Snapshot requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from bit 0: button_word[16], trigger_left[8], trigger_right[8], stick_left_x[16],
  // stick_left_y[16], stick_right_x[16], stick_right_y[16], sequence_count[8]
  input  logic [103:0] s_axis_tdata,
  // Report bytes
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // from bit 0: byte_index[6], byte_value[8], two zero bits
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned LW = gprf_pkg::LEN_W;

  // Scale a stick axis to 0..255: floor(off / 257) by reciprocal and one correction
  function automatic logic [7:0] scale_axis(input logic [15:0] v, input logic invert);
    logic [15:0] off;
    logic [23:0] p;
    logic [7:0]  q1;
    logic [16:0] r;
    logic [7:0]  q;
    off = invert ? (v ^ 16'h7FFF) : (v ^ 16'h8000);
    p   = {8'h00, off} * 24'd255;
    q1  = p[23:16];
    r   = {1'b0, p[15:0]} + {9'h000, q1};
    q   = (r >= 17'd65535) ? (q1 + 8'd1) : q1;
    return (v == 16'h0000) ? 8'h80 : q;
  endfunction

  // Configuration registers
  logic [1:0]    report_format;
  logic [7:0]    trigger_threshold;
  logic [LW-1:0] report_length;
  logic [7:0]    report_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_format     <= gprf_pkg::FMT_LAYOUT2;
      trigger_threshold <= 8'd128;
      report_length     <= LW'(64);
      report_tag        <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        gprf_pkg::REG_FORMAT:    report_format     <= cfg_data[1:0];
        gprf_pkg::REG_THRESHOLD: trigger_threshold <= cfg_data;
        gprf_pkg::REG_LENGTH:    report_length     <= cfg_data[LW-1:0];
        gprf_pkg::REG_ID:        report_tag        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective report length, clamped
  logic [LW-1:0] len_eff;

  always_comb begin
    if (report_length == '0) begin
      len_eff = LW'(1);
    end else if (report_length > LW'(MAX_REPORT_BYTES)) begin
      len_eff = LW'(MAX_REPORT_BYTES);
    end else begin
      len_eff = report_length;
    end
  end

  // Incoming snapshot
  gprf_pkg::snap_t snap_in;

  assign snap_in.buttons = s_axis_tdata[15:0];
  assign snap_in.trig_l  = s_axis_tdata[23:16];
  assign snap_in.trig_r  = s_axis_tdata[31:24];
  assign snap_in.lx      = scale_axis(s_axis_tdata[47:32], 1'b0);
  assign snap_in.ly      = scale_axis(s_axis_tdata[63:48], 1'b1);
  assign snap_in.rx      = scale_axis(s_axis_tdata[79:64], 1'b0);
  assign snap_in.ry      = scale_axis(s_axis_tdata[95:80], 1'b1);
  assign snap_in.count   = s_axis_tdata[103:96];

  // Buffer control
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       in_acc;
  logic       rd_issue;

  // Sequencer and output register
  gprf_pkg::snap_t rd_data;
  logic            have;
  logic [5:0]      idx;
  logic            load;
  logic            last;
  logic [7:0]      byte_val;
  logic            out_valid;
  logic [5:0]      out_idx;
  logic [7:0]      out_byte;
  logic            out_last;

  gprf_pkg::snap_t mem [2];

  assign s_axis_tready = (pending != 2'd2);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign load          = have & (~out_valid | m_axis_tready);
  assign last          = ({1'b0, idx} == (len_eff - LW'(1)));
  // Fetch the next entry when idle or once the current report hands over its final byte
  assign rd_issue      = (pending != 2'd0) & (~have | (load & last));

  always_comb begin
    pending_next = pending;
    if (in_acc && !rd_issue) begin
      pending_next = pending + 2'd1;
    end else if (!in_acc && rd_issue) begin
      pending_next = pending - 2'd1;
    end
  end

  // Buffer memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wr_ptr] <= snap_in;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      pending <= 2'd0;
      have    <= 1'b0;
      idx     <= 6'd0;
    end else begin
      pending <= pending_next;
      if (in_acc) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_issue) begin
        rd_ptr <= ~rd_ptr;
        have   <= 1'b1;
      end else if (load && last) begin
        have <= 1'b0;
      end
      if (load) begin
        idx <= last ? 6'd0 : (idx + 6'd1);
      end
    end
  end

  gprf_pkg::cfg_t cfg_live;

  assign cfg_live.format    = report_format;
  assign cfg_live.threshold = trigger_threshold;
  assign cfg_live.id        = report_tag;

  gprf_byte_gen u_byte_gen (
    .snap  (rd_data),
    .cfg   (cfg_live),
    .idx   (idx),
    .value (byte_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      out_idx  <= idx;
      out_byte <= byte_val;
      out_last <= last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_byte, out_idx};
  assign m_axis_tlast  = out_last;

endmodule

@@ tb/tb_gamepad_report_formatter_core.sv @@
// Self-checking testbench for the gamepad report formatter core.
`timescale 1ns / 1ps

module tb_gamepad_report_formatter_core;

  localparam logic [1:0] FMT_UNUSED   = 2'd3;
  localparam int         REPORT_MAX   = 64;
  localparam int         CYCLE_LIMIT  = 500000;

  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_NEUTRAL    = 4'd8;

  typedef struct {
    logic [15:0] buttons;
    logic [7:0]  trig_l;
    logic [7:0]  trig_r;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [7:0]  count;
  } pad_sample_t;

  typedef struct {
    logic [5:0] index;
    logic [7:0] value;
    logic       last;
  } report_byte_t;

  class report_scoreboard;
    logic [1:0]   fmt;
    logic [7:0]   threshold;
    logic [6:0]   length;
    logic [7:0]   report_tag;
    report_byte_t expected_bytes[$];
    int           errors;

    function new();
      fmt        = gprf_pkg::FMT_LAYOUT2;
      threshold  = 8'd128;
      length     = 7'd64;
      report_tag = 8'd1;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        gprf_pkg::REG_FORMAT:    fmt        = val[1:0];
        gprf_pkg::REG_THRESHOLD: threshold  = val;
        gprf_pkg::REG_LENGTH:    length     = val[6:0];
        gprf_pkg::REG_ID:        report_tag = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] scale_x(logic [15:0] v);
      int unsigned off;
      off = 32'(v ^ 16'h8000);
      if (v == 16'h0000) return 8'h80;
      return 8'((off * 255) / 65535);
    endfunction

    function logic [7:0] scale_y(logic [15:0] v);
      int unsigned off;
      off = 65535 - 32'(v ^ 16'h8000);
      if (v == 16'h0000) return 8'h80;
      return 8'((off * 255) / 65535);
    endfunction

    // Opposing directions cancel on their own axis
    function logic [3:0] hat_of(logic [15:0] b);
      logic up, dn, h_r, h_l;
      up  = b[0] & ~b[1];
      dn  = b[1] & ~b[0];
      h_r = b[3] & ~b[2];
      h_l = b[2] & ~b[3];
      if (up) return h_r ? HAT_UP_RIGHT : (h_l ? HAT_UP_LEFT : HAT_UP);
      if (dn) return h_r ? HAT_DOWN_RIGHT : (h_l ? HAT_DOWN_LEFT : HAT_DOWN);
      if (h_r) return HAT_RIGHT;
      if (h_l) return HAT_LEFT;
      return HAT_NEUTRAL;
    endfunction

    function void note_snapshot(pad_sample_t s);
      logic [7:0]   r[REPORT_MAX];
      logic [15:0]  b;
      logic         ltd, rtd;
      logic [7:0]   lx, ly, rx, ry;
      logic [15:0]  ts;
      int           n;
      report_byte_t e;
      b   = s.buttons;
      ltd = s.trig_l >= threshold;
      rtd = s.trig_r >= threshold;
      lx  = scale_x(s.lx);
      ly  = scale_y(s.ly);
      rx  = scale_x(s.rx);
      ry  = scale_y(s.ry);
      ts  = {6'd0, s.count, 2'b00};
      for (int i = 0; i < REPORT_MAX; i++) r[i] = 8'h00;
      if (fmt == gprf_pkg::FMT_GENERIC) begin
        r[0] = {rtd, ltd, b[9], b[8], b[15], b[13], b[12], b[14]};
        r[1] = {4'd0, b[7], b[6], b[4], b[5]};
        r[2] = lx; r[3] = ly; r[4] = rx; r[5] = ry;
        r[6] = s.trig_l; r[7] = s.trig_r;
      end else if (fmt == gprf_pkg::FMT_LAYOUT1) begin
        r[0]  = report_tag;
        r[2]  = {b[2], b[1], b[3], b[0], b[4], b[7], b[6], b[5]};
        r[3]  = {b[14], b[12], b[13], b[15], b[9], b[8], rtd, ltd};
        r[4]  = {7'd0, b[10]};
        r[6]  = lx; r[7] = ly; r[8] = rx; r[9] = ry;
        r[14] = {8{b[0]}};  r[15] = {8{b[3]}};
        r[16] = {8{b[1]}};  r[17] = {8{b[2]}};
        r[18] = s.trig_l;   r[19] = s.trig_r;
        r[20] = {8{b[8]}};  r[21] = {8{b[9]}};
        r[22] = {8{b[15]}}; r[23] = {8{b[13]}};
        r[24] = {8{b[12]}}; r[25] = {8{b[14]}};
        r[29] = 8'h02; r[30] = 8'h05; r[31] = 8'h10;
        for (int i = 41; i <= 47; i += 2) begin
          r[i]     = 8'h01;
          r[i + 1] = 8'hFF;
        end
      end else begin
        // the unused code falls through to this layout as well
        r[0]  = report_tag;
        r[1]  = lx; r[2] = ly; r[3] = rx; r[4] = ry;
        r[5]  = {b[15], b[13], b[12], b[14], hat_of(b)};
        r[6]  = {b[7], b[6], b[4], b[5], rtd, ltd, b[9], b[8]};
        r[7]  = {s.count[5:0], 1'b0, b[10]};
        r[8]  = s.trig_l; r[9] = s.trig_r;
        r[10] = ts[7:0];  r[11] = ts[15:8];
        r[30] = 8'h1B;    r[33] = 8'h01;
      end
      n = int'(length);
      if (n == 0) n = 1;
      if (n > REPORT_MAX) n = REPORT_MAX;
      for (int i = 0; i < n; i++) begin
        e.index = 6'(i);
        e.value = r[i];
        e.last  = (i + 1 == n);
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_byte(logic [5:0] idx, logic [7:0] val, logic last);
      report_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("report byte %0d arrived with nothing expected", idx);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (idx !== e.index) begin
        $error("byte_index: expected %0d, got %0d", e.index, idx);
        errors++;
      end
      if (val !== e.value) begin
        $error("byte_value at %0d: expected 0x%02h, got 0x%02h", e.index, e.value, val);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_byte at %0d: expected %0b, got %0b", e.index, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tlast;

  report_scoreboard sb;
  int tx_idle_pct = 13;
  int rx_idle_pct = 50;
  int cycle_count = 0;

  gamepad_report_formatter_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_byte(m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tlast);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_pad(input logic [15:0] btn, input logic [7:0] tl, input logic [7:0] tr,
                          input logic [15:0] lx, input logic [15:0] ly,
                          input logic [15:0] rx, input logic [15:0] ry,
                          input logic [7:0] cnt);
    pad_sample_t s;
    s = '{btn, tl, tr, lx, ly, rx, ry, cnt};
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cnt, ry, rx, ly, lx, tr, tl, btn};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_snapshot(s);
  endtask

  // Hold off requests until every report byte has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic [7:0] thr,
                            input logic [6:0] len, input logic [7:0] id);
    wait_idle();
    write_reg(gprf_pkg::REG_FORMAT, {6'd0, fmt});
    write_reg(gprf_pkg::REG_THRESHOLD, thr);
    write_reg(gprf_pkg::REG_LENGTH, {1'b0, len});
    write_reg(gprf_pkg::REG_ID, id);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_trigger(logic [7:0] thr);
    case ($urandom_range(0, 3))
      0: return thr;
      1: return thr - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_config();
    logic [6:0] len;
    logic [7:0] thr;
    case ($urandom_range(0, 7))
      0: len = 7'd0;
      1: len = 7'd64;
      2: len = 7'($urandom_range(65, 127));
      default: len = 7'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 3))
      0: thr = 8'd0;
      1: thr = 8'd255;
      default: thr = 8'($urandom_range(0, 255));
    endcase
    set_config(2'($urandom_range(0, 3)), thr, len, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset layout: extremes, exact zero axes, threshold edges, every hat direction
    send_pad(16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0);
    send_pad(16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 8'd255);
    send_pad(16'h0001, 8'd128, 8'd127, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 8'd63);
    send_pad(16'h0009, 8'd127, 8'd128, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'd64);
    send_pad(16'h0008, 8'd1, 8'd254, 16'h1234, 16'hEDCB, 16'h0000, 16'h4000, 8'd192);
    send_pad(16'h000A, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1);
    send_pad(16'h0002, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd2);
    send_pad(16'h0006, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd3);
    send_pad(16'h0004, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd4);
    send_pad(16'h0005, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd5);
    // opposing directions: up with down, left with right, all four
    send_pad(16'h000B, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd6);
    send_pad(16'h000D, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd7);
    send_pad(16'h000F, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd8);
    send_pad(16'hF7F0, 8'd200, 8'd50, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 8'd170);

    set_config(gprf_pkg::FMT_GENERIC, 8'd255, 7'd8, 8'd0);
    send_pad(16'hFFFF, 8'd255, 8'd254, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 8'd9);
    send_pad(16'h5AA5, 8'd0, 8'd255, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 8'd10);

    set_config(gprf_pkg::FMT_LAYOUT1, 8'd0, 7'd64, 8'd255);
    send_pad(16'hFFFF, 8'd0, 8'd255, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 8'd11);
    send_pad(16'hA55A, 8'd17, 8'd0, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 8'd12);

    set_config(FMT_UNUSED, 8'd128, 7'd127, 8'h5A);
    send_pad(16'h0003, 8'd128, 8'd127, 16'h4321, 16'hBCDE, 16'h0000, 16'h8000, 8'd255);
    set_config(gprf_pkg::FMT_LAYOUT2, 8'd1, 7'd0, 8'hA5);
    send_pad(16'h1234, 8'd0, 8'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd33);
    set_config(gprf_pkg::FMT_LAYOUT1, 8'd200, 7'd1, 8'h01);
    send_pad(16'hFFFF, 8'd200, 8'd199, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 8'd77);
    set_config(gprf_pkg::FMT_GENERIC, 8'd128, 7'd65, 8'd1);
    send_pad(16'hEDCB, 8'd128, 8'd128, 16'hFFFF, 16'h0001, 16'h0000, 16'h7FFF, 8'd128);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 13; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // each group starts from an empty pipeline with a fresh setting
      for (int grp = 0; grp < 6; grp++) begin
        random_config();
        for (int k = 0; k < 8; k++)
          send_pad(16'($urandom_range(0, 65535)), rand_trigger(sb.threshold),
                   rand_trigger(sb.threshold), rand_axis(), rand_axis(), rand_axis(),
                   rand_axis(), 8'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
sv/gprf_pkg.sv
sv/gprf_byte_gen.sv
sv/gamepad_report_formatter_core.sv
tb/tb_gamepad_report_formatter_core.sv
